// ----- design/mlpq_pkg.sv -----
// Package for the multilevel priority queue: request and status codes,
// default sizes and the response struct passed from control to top level.
// No dependencies.
package mlpq_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int PKG_LEVELS = 8;
	localparam int PKG_DEPTH  = 128;

	// Field widths fixed by the interface
	localparam int VALUE_W  = 32;
	localparam int LEVEL_W  = 3;
	localparam int STATUS_W = 2;

	// Request opcodes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_ENQ = 2'd0;
	localparam status_t ST_OVF = 2'd1;
	localparam status_t ST_DEQ = 2'd2;
	localparam status_t ST_UNF = 2'd3;

	// Response of the control unit, valid in the cycle after a request
	typedef struct packed {
		logic               done;
		status_t            status;
		logic [LEVEL_W-1:0] level;
	} resp_t;

endpackage

// ----- design/mlpq_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module mlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- design/mlpq_ctrl.sv -----
// Queue control: per-level head/tail pointers and fill counts, priority
// encoder over the non-empty levels, entry memory address generation.
// Depends on mlpq_pkg.
module mlpq_ctrl import mlpq_pkg::*; #(
	parameter int LEVELS = PKG_LEVELS,
	parameter int DEPTH  = PKG_DEPTH,
	localparam int LW = $clog2(LEVELS),
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = $clog2(LEVELS * DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               op,
	input  logic [LEVEL_W-1:0] level,
	output logic               mem_we,
	output logic               mem_re,
	output logic [AW-1:0]      mem_addr,
	output resp_t              resp
);

	logic [PW-1:0] head_q [LEVELS];
	logic [PW-1:0] tail_q [LEVELS];
	logic [CW-1:0] cnt_q  [LEVELS];

	logic             done_q;
	status_t          status_q;
	logic [LEVEL_W-1:0] level_q;

	logic [LW+LEVEL_W-1:0] lvl_ext;
	logic [LW+LEVEL_W-1:0] deq_ext;
	logic [LW-1:0]         enq_idx;
	logic [LW-1:0]         deq_idx;
	logic [LW-1:0]         sel_idx;
	logic [PW-1:0]         sel_ptr;
	logic                  lvl_ok;
	logic                  enq_ok;
	logic                  any_ne;

	// Enqueue target: level must exist and its ring must have room
	always_comb begin
		lvl_ext = (LW + LEVEL_W)'(level);
		enq_idx = lvl_ext[LW-1:0];
		lvl_ok  = (32'(level) < 32'(LEVELS));
		enq_ok  = lvl_ok && (cnt_q[enq_idx] != CW'(DEPTH));
	end

	// Priority encoder: lowest-numbered non-empty level wins
	always_comb begin
		any_ne  = 1'b0;
		deq_idx = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				any_ne  = 1'b1;
				deq_idx = LW'(i);
			end
		end
		deq_ext = (LW + LEVEL_W)'(deq_idx);
	end

	// Entry address: ring base plus head (dequeue) or tail (enqueue)
	always_comb begin
		sel_idx  = (op == OP_DEQ) ? deq_idx : enq_idx;
		sel_ptr  = (op == OP_DEQ) ? head_q[deq_idx] : tail_q[enq_idx];
		mem_addr = AW'(sel_idx) * AW'(DEPTH) + AW'(sel_ptr);
		mem_we   = accept && (op == OP_ENQ) && enq_ok;
		mem_re   = accept && (op == OP_DEQ) && any_ne;
	end

	// Pointer and count update, wrapping at DEPTH-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (mem_we) begin
				tail_q[enq_idx] <= (tail_q[enq_idx] == PW'(DEPTH - 1)) ? '0
				                   : tail_q[enq_idx] + 1'b1;
				cnt_q[enq_idx]  <= cnt_q[enq_idx] + 1'b1;
			end
			if (mem_re) begin
				head_q[deq_idx] <= (head_q[deq_idx] == PW'(DEPTH - 1)) ? '0
				                   : head_q[deq_idx] + 1'b1;
				cnt_q[deq_idx]  <= cnt_q[deq_idx] - 1'b1;
			end
		end
	end

	// Response fields for the request just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_ENQ;
			level_q  <= '0;
		end else if (accept) begin
			if (op == OP_ENQ) begin
				status_q <= enq_ok ? ST_ENQ : ST_OVF;
				level_q  <= '0;
			end else if (any_ne) begin
				status_q <= ST_DEQ;
				level_q  <= deq_ext[LEVEL_W-1:0];
			end else begin
				status_q <= ST_UNF;
				level_q  <= '0;
			end
		end
	end

	assign resp.done   = done_q;
	assign resp.status = status_q;
	assign resp.level  = level_q;

`ifndef SYNTH
	a_unf_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_DEQ) && !any_ne |=> status_q == ST_UNF)
		else $error("dequeue with all levels empty did not report underflow");
	a_deq_when_ne: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> status_q == ST_DEQ && done_q)
		else $error("memory read issued without dequeue response");
	a_enq_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> status_q == ST_ENQ && done_q)
		else $error("memory write issued without enqueue response");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("read and write to entry memory in one cycle");
`endif

endmodule

// ----- design/multilevel_priority_fifo_queue.sv -----
// Strict-priority queue, one ring per level held in a single entry memory.
// The result strobe done rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, since each request makes
// at most one access of the single-port entry memory and pointers update at once.
// Reset clears pointers and fill counts at once; the entry memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module multilevel_priority_fifo_queue import mlpq_pkg::*; #(
	parameter int LEVELS = PKG_LEVELS,
	parameter int DEPTH  = PKG_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [LEVEL_W-1:0]         level,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [LEVEL_W-1:0]         out_level
);

	localparam int AW = $clog2(LEVELS * DEPTH);

	logic               accept;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      mem_addr;
	logic [VALUE_W-1:0] mem_rdata;
	resp_t              resp;

	// Every request is taken in the cycle it is raised
	assign busy   = 1'b0;
	assign accept = start && !busy;

	mlpq_ctrl #(
		.LEVELS(LEVELS),
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op),
		.level   (level),
		.mem_we  (mem_we),
		.mem_re  (mem_re),
		.mem_addr(mem_addr),
		.resp    (resp)
	);

	mlpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(LEVELS * DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(value),
		.rdata(mem_rdata)
	);

	// Result ports; the word is the memory read data on a dequeue, else zero
	assign done      = resp.done;
	assign status    = resp.status;
	assign out_level = resp.level;
	assign out_value = (resp.status == ST_DEQ) ? mem_rdata : '0;

`ifndef SYNTH
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("request taken without a result next cycle");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without a request");
	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_DEQ) |-> out_level == '0 && out_value == '0)
		else $error("nonzero word or level on a non-dequeue result");
`endif

endmodule
